@@ rtl/core/eea_pkg.sv @@
`default_nettype none

package eea_pkg;

	localparam int ANGLE_BITS_DEF  = 14;
	localparam int MAX_SAMPLES_DEF = 256;
	localparam int PP_W            = 7;
	localparam int SC_W            = 9;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 9;
	localparam int KIND_W          = 2;
	localparam int OP_W            = 2;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [PP_W-1:0] PP_RESET = 7'd1;
	localparam logic [SC_W-1:0] SC_RESET = 9'd16;

	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;

	localparam logic RES_CONVERT = 1'b0;
	localparam logic RES_CALIB   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE  = 2'd0,
		OP_CONVERT = 2'd1,
		OP_LOAD    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_PAIRS   = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CONV,
		ST_ACC,
		ST_DIV,
		ST_FIX,
		ST_CMUL,
		ST_CAL_OUT
	} back_state_t;

	typedef struct packed {
		logic [PP_W-1:0] pair_cnt;
		logic [SC_W-1:0] avg_len;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/eea_if.sv @@
`default_nettype none

interface eea_sample_if #(
	parameter int ANGLE_BITS = eea_pkg::ANGLE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [eea_pkg::KIND_W-1:0]  kind;
	logic [ANGLE_BITS-1:0]       angle_in;

	modport source (output valid, output kind, output angle_in, input ready);
	modport sink (input valid, input kind, input angle_in, output ready);
endinterface

interface eea_result_if #(
	parameter int ANGLE_BITS = eea_pkg::ANGLE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  result_kind;
	logic [ANGLE_BITS-1:0] angle_out;

	modport source (output valid, output result_kind, output angle_out, input ready);
	modport sink (input valid, input result_kind, input angle_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/eea_queue.sv @@
`default_nettype none

module eea_queue #(
	parameter int DATA_W = eea_pkg::OP_W + eea_pkg::ANGLE_BITS_DEF,
	parameter int DEPTH  = eea_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic      [DATA_W-1:0] pop_data,
	output logic                   full,
	output logic                   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/eea_front.sv @@
`default_nettype none

module eea_front #(
	parameter int ANGLE_BITS = eea_pkg::ANGLE_BITS_DEF
) (
	eea_sample_if.sink                                   sample_ch,
	input  wire logic                                    q_full,
	output logic                                         push,
	output logic [eea_pkg::OP_W+ANGLE_BITS-1:0]          push_data
);

	logic        accept;
	eea_pkg::op_t op;

	assign sample_ch.ready = !q_full;
	assign accept          = sample_ch.valid && !q_full;
	assign push_data       = {op, sample_ch.angle_in};

	// drop the unused kind code here
	always_comb begin
		push = 1'b0;
		op   = eea_pkg::OP_SAMPLE;
		unique case (sample_ch.kind)
			eea_pkg::KIND_SAMPLE: begin
				push = accept;
				op   = eea_pkg::OP_SAMPLE;
			end
			eea_pkg::KIND_CONVERT: begin
				push = accept;
				op   = eea_pkg::OP_CONVERT;
			end
			eea_pkg::KIND_LOAD: begin
				push = accept;
				op   = eea_pkg::OP_LOAD;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/eea_back.sv @@
`default_nettype none

module eea_back #(
	parameter int ANGLE_BITS  = eea_pkg::ANGLE_BITS_DEF,
	parameter int MAX_SAMPLES = eea_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire eea_pkg::cfg_t                        cfg,
	input  wire logic                                 q_empty,
	input  wire logic [eea_pkg::OP_W+ANGLE_BITS-1:0]  q_data,
	output logic                                      pop,
	eea_result_if.source                              result_ch
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int TERM_W = ANGLE_BITS + 2;
	localparam int SUM_W  = ANGLE_BITS + 2 + CNT_W;
	localparam int DIV_CW = $clog2(SUM_W + 1);
	localparam int PROD_W = ANGLE_BITS + eea_pkg::PP_W;

	localparam logic signed [TERM_W-1:0] HALF_S     = TERM_W'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [TERM_W-1:0] TURN_S     = TERM_W'(2 ** ANGLE_BITS);
	localparam logic signed [TERM_W-1:0] NEG_HALF_S = -HALF_S;

	eea_pkg::back_state_t state_q, state_d;

	logic [ANGLE_BITS-1:0]   angle_q;
	logic [ANGLE_BITS-1:0]   prod_q;
	logic [ANGLE_BITS-1:0]   offset_q;
	logic [ANGLE_BITS-1:0]   first_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        index_q;
	logic [SUM_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        divisor_q;
	logic                    neg_q;
	logic [DIV_CW-1:0]       div_cnt_q;
	logic                    out_valid_q;
	logic                    out_kind_q;
	logic [ANGLE_BITS-1:0]   out_angle_q;

	eea_pkg::op_t            q_op;
	logic [ANGLE_BITS-1:0]   q_angle;
	logic                    slot_free;
	logic                    load_out;
	logic [PROD_W-1:0]       prod;
	logic [31:0]             sc_ext;
	logic [CNT_W-1:0]        eff_count;
	logic [CNT_W-1:0]        idx_next;
	logic                    run_done;
	logic signed [TERM_W-1:0] delta_raw;
	logic signed [TERM_W-1:0] delta;
	logic signed [TERM_W-1:0] term;
	logic signed [SUM_W-1:0]  sum_base;
	logic signed [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]        sum_abs;
	logic [CNT_W:0]          rem_sh;
	logic                    rem_ge;
	logic [CNT_W-1:0]        rem_next;
	logic [SUM_W-1:0]        quot;

	assign q_op    = eea_pkg::op_t'(q_data[eea_pkg::OP_W+ANGLE_BITS-1:ANGLE_BITS]);
	assign q_angle = q_data[ANGLE_BITS-1:0];

	assign result_ch.valid       = out_valid_q;
	assign result_ch.result_kind = out_kind_q;
	assign result_ch.angle_out   = out_angle_q;
	assign slot_free             = !out_valid_q || result_ch.ready;
	assign load_out              = slot_free &&
		(state_q == eea_pkg::ST_CONV || state_q == eea_pkg::ST_CAL_OUT);

	assign prod = PROD_W'(angle_q) * PROD_W'(cfg.pair_cnt);

	// effective sample count: zero reads as one, saturate at the maximum
	assign sc_ext = 32'(cfg.avg_len);
	always_comb begin
		if (sc_ext == 32'd0) begin
			eff_count = CNT_W'(1);
		end else if (sc_ext > 32'(MAX_SAMPLES)) begin
			eff_count = CNT_W'(MAX_SAMPLES);
		end else begin
			eff_count = CNT_W'(sc_ext);
		end
	end

	assign idx_next = CNT_W'(index_q + 1'b1);
	assign run_done = (idx_next >= eff_count);

	// unwrap to within half a turn of the first sample
	always_comb begin
		delta_raw = $signed({2'b00, angle_q}) - $signed({2'b00, first_q});
		if (delta_raw > HALF_S - TERM_W'(1)) begin
			delta = delta_raw - TURN_S;
		end else if (delta_raw < NEG_HALF_S) begin
			delta = delta_raw + TURN_S;
		end else begin
			delta = delta_raw;
		end
		if (index_q == '0) begin
			term     = $signed({2'b00, angle_q});
			sum_base = '0;
		end else begin
			term     = $signed({2'b00, first_q}) + delta;
			sum_base = sum_q;
		end
		sum_next = sum_base + SUM_W'(term);
		sum_abs  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
	end

	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, divisor_q});
	assign rem_next = rem_ge ? CNT_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[CNT_W-1:0];
	assign quot     = neg_q ? SUM_W'(SUM_W'(0) - dvd_q) : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eea_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			eea_pkg::ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (q_op)
						eea_pkg::OP_CONVERT: state_d = eea_pkg::ST_MUL;
						eea_pkg::OP_SAMPLE:  state_d = eea_pkg::ST_ACC;
						default:             state_d = eea_pkg::ST_IDLE;
					endcase
				end
			end
			eea_pkg::ST_MUL: state_d = eea_pkg::ST_CONV;
			eea_pkg::ST_CONV: begin
				if (slot_free) begin
					state_d = eea_pkg::ST_IDLE;
				end
			end
			eea_pkg::ST_ACC: begin
				state_d = run_done ? eea_pkg::ST_DIV : eea_pkg::ST_IDLE;
			end
			eea_pkg::ST_DIV: begin
				if (div_cnt_q == DIV_CW'(1)) begin
					state_d = eea_pkg::ST_FIX;
				end
			end
			eea_pkg::ST_FIX:  state_d = eea_pkg::ST_CMUL;
			eea_pkg::ST_CMUL: state_d = eea_pkg::ST_CAL_OUT;
			eea_pkg::ST_CAL_OUT: begin
				if (slot_free) begin
					state_d = eea_pkg::ST_IDLE;
				end
			end
			default: state_d = eea_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			first_q     <= '0;
			sum_q       <= '0;
			index_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.valid && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				eea_pkg::ST_IDLE: begin
					if (pop && q_op == eea_pkg::OP_LOAD) begin
						offset_q <= q_angle;
					end
				end
				eea_pkg::ST_ACC: begin
					if (run_done) begin
						index_q <= '0;
						first_q <= '0;
						sum_q   <= '0;
					end else begin
						index_q <= idx_next;
						sum_q   <= sum_next;
						if (index_q == '0) begin
							first_q <= angle_q;
						end
					end
				end
				eea_pkg::ST_CMUL: begin
					offset_q <= prod[ANGLE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			eea_pkg::ST_IDLE: begin
				if (pop) begin
					angle_q <= q_angle;
				end
			end
			eea_pkg::ST_MUL: begin
				prod_q <= prod[ANGLE_BITS-1:0];
			end
			eea_pkg::ST_CONV: begin
				if (slot_free) begin
					out_kind_q  <= eea_pkg::RES_CONVERT;
					out_angle_q <= ANGLE_BITS'(prod_q - offset_q);
				end
			end
			eea_pkg::ST_ACC: begin
				dvd_q     <= sum_abs;
				neg_q     <= sum_next[SUM_W-1];
				divisor_q <= idx_next;
				rem_q     <= '0;
				div_cnt_q <= DIV_CW'(SUM_W);
			end
			eea_pkg::ST_DIV: begin
				dvd_q     <= {dvd_q[SUM_W-2:0], rem_ge};
				rem_q     <= rem_next;
				div_cnt_q <= DIV_CW'(div_cnt_q - 1'b1);
			end
			eea_pkg::ST_FIX: begin
				angle_q <= quot[ANGLE_BITS-1:0];
			end
			eea_pkg::ST_CAL_OUT: begin
				if (slot_free) begin
					out_kind_q  <= eea_pkg::RES_CALIB;
					out_angle_q <= angle_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/encoder_electrical_alignment_top.sv @@
// Convert: popped in ST_IDLE, multiplied in ST_MUL, result registered in ST_CONV. The last
// calibration sample passes ST_ACC, the bit-serial restoring divider in ST_DIV, ST_FIX,
// ST_CMUL and ST_CAL_OUT; other samples pass ST_ACC only, and loads are taken in ST_IDLE.
// The back end handles one item at a time; a two-entry queue accepts while it works.
// Reset: arst_n clears the queue, the state machine, the run state, the offset
// and the output valid; the pole-pair register returns to 1 and the sample count to 16.
`default_nettype none

module encoder_electrical_alignment_top #(
	parameter int ANGLE_BITS  = eea_pkg::ANGLE_BITS_DEF,
	parameter int MAX_SAMPLES = eea_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	eea_sample_if.sink                            sample_ch,
	eea_result_if.source                          result_ch,
	input  wire logic                             cfg_we,
	input  wire logic [eea_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [eea_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int QDATA_W = eea_pkg::OP_W + ANGLE_BITS;

	logic [eea_pkg::PP_W-1:0] pair_cnt_q;
	logic [eea_pkg::SC_W-1:0] avg_len_q;
	eea_pkg::cfg_t            cfg;

	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	logic [QDATA_W-1:0] push_data;
	logic [QDATA_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cnt_q <= eea_pkg::PP_RESET;
			avg_len_q  <= eea_pkg::SC_RESET;
		end else if (cfg_we) begin
			unique case (eea_pkg::cfg_reg_t'(cfg_idx))
				eea_pkg::REG_POLE_PAIRS:   pair_cnt_q <= cfg_wdata[eea_pkg::PP_W-1:0];
				eea_pkg::REG_SAMPLE_COUNT: avg_len_q  <= cfg_wdata[eea_pkg::SC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = eea_pkg::cfg_t'{pair_cnt: pair_cnt_q, avg_len: avg_len_q};

	eea_front #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_front (
		.sample_ch (sample_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	eea_queue #(
		.DATA_W (QDATA_W),
		.DEPTH  (eea_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	eea_back #(
		.ANGLE_BITS  (ANGLE_BITS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.result_ch (result_ch)
	);

endmodule

`default_nettype wire

@@ rtl/core/eea_checker.sv @@
`default_nettype none

module eea_checker #(
	parameter int ANGLE_BITS = eea_pkg::ANGLE_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [eea_pkg::KIND_W-1:0]    in_kind,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          out_kind,
	input wire logic [ANGLE_BITS-1:0]         out_angle
);

	logic        in_acc;
	logic        out_acc;
	logic        conv_in;
	logic        conv_out;
	logic        cal_out;
	logic        samp_in;
	logic [3:0]  conv_pend_q;
	logic [15:0] samp_pend_q;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign conv_in  = in_acc && (in_kind == eea_pkg::KIND_CONVERT);
	assign conv_out = out_acc && (out_kind == eea_pkg::RES_CONVERT);
	assign cal_out  = out_acc && (out_kind == eea_pkg::RES_CALIB);
	assign samp_in  = in_acc && (in_kind == eea_pkg::KIND_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_pend_q <= '0;
			samp_pend_q <= '0;
		end else begin
			if (conv_in && !conv_out) begin
				conv_pend_q <= 4'(conv_pend_q + 1'b1);
			end else if (conv_out && !conv_in) begin
				conv_pend_q <= 4'(conv_pend_q - 1'b1);
			end
			if (samp_in && !cal_out) begin
				samp_pend_q <= 16'(samp_pend_q + 1'b1);
			end else if (cal_out && !samp_in) begin
				samp_pend_q <= 16'(samp_pend_q - 1'b1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_angle))
		else $error("result changed while stalled");

	a_conv_origin: assert property (@(posedge clk) disable iff (!arst_n)
		conv_out |-> conv_pend_q != 4'd0)
		else $error("convert result without pending convert transaction");

	a_cal_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cal_out |-> samp_pend_q != 16'd0)
		else $error("calibration result without sample transaction");

	a_conv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		conv_pend_q <= 4'd4)
		else $error("more convert transactions in flight than storage allows");

endmodule

bind encoder_electrical_alignment_top eea_checker #(
	.ANGLE_BITS (ANGLE_BITS)
) u_eea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.in_kind   (sample_ch.kind),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_kind  (result_ch.result_kind),
	.out_angle (result_ch.angle_out)
);

`default_nettype wire
